### hdl/list_mode_finder_assert.svh
// Assertion macros for the list mode finder.
// Included by the modules that check their own logic; no other dependencies.
`ifndef LIST_MODE_FINDER_ASSERT_SVH
`define LIST_MODE_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
`define LMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list_mode_finder: assertion failed");
`define LMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list_mode_finder: assertion failed");
`else
`define LMF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/lmf_pkg.sv
// Shared constants, state encoding and control structs of the list mode finder.
// No dependencies.
`default_nettype none
package lmf_pkg;
    localparam int MAX_ITEMS  = 32;
    localparam int VALUE_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int NUM_W      = $clog2(MAX_ITEMS + 1);
    localparam int COUNT_W    = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND_RD,
        S_CAND_LAT,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_DONE
    } lmf_state_t;

    typedef struct packed {
        logic load;
        logic cand_rd;
        logic cand_lat;
        logic scan_issue;
        logic update;
        logic done;
    } lmf_cmd_t;

    typedef struct packed {
        logic k_last;
        logic i_last;
        logic out_free;
    } lmf_sts_t;
endpackage
`default_nettype wire

### hdl/list_mode_finder.sv
// Top level of the list mode finder: joins controller lmf_ctrl and datapath lmf_dp.
// Depends on lmf_pkg, lmf_ctrl and lmf_dp.
//
// Takes a list of values, one beat per cycle while in_stall is low, into a 32-entry
// store; the beat with last_item set closes the list and yields one result beat with
// the most frequent value (earliest on ties), its count, and an overflow flag when
// beats beyond 32 were dropped. After the last beat the block holds in_stall high
// through the count scan, which reads the store through its one read port once per
// entry for every candidate entry, and longer while an earlier result still waits in
// the output register. The result waits in that output register; a new list may load
// while it waits.
`default_nettype none
module list_mode_finder
    import lmf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [VALUE_BITS-1:0] item_value,
    input  wire logic                  last_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [VALUE_BITS-1:0]      mode_value,
    output logic [COUNT_W-1:0]         mode_count,
    output logic                       overflowed
);
    lmf_cmd_t cmd;
    lmf_sts_t sts;

    lmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_item (last_item),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lmf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_value (item_value),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mode_value (mode_value),
        .mode_count (mode_count),
        .overflowed (overflowed)
    );
endmodule
`default_nettype wire

### hdl/lmf_ctrl.sv
// Controller state machine of the list mode finder.
// Depends on lmf_pkg; drives the datapath lmf_dp through command and status structs.
`default_nettype none
module lmf_ctrl
    import lmf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     last_item,
    output logic          in_stall,
    input  wire lmf_sts_t sts,
    output lmf_cmd_t      cmd
);
    lmf_state_t state_reg;
    lmf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && last_item)
                begin
                    state_next = S_CAND_RD;
                end
            end
            S_CAND_RD:  state_next = S_CAND_LAT;
            S_CAND_LAT: state_next = S_SCAN;
            S_SCAN:
            begin
                if (sts.k_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:    state_next = S_UPDATE;
            S_UPDATE:
            begin
                state_next = sts.i_last ? S_DONE : S_CAND_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_CAND_RD:  cmd.cand_rd    = 1'b1;
            S_CAND_LAT: cmd.cand_lat   = 1'b1;
            S_SCAN:     cmd.scan_issue = 1'b1;
            S_DRAIN:    cmd            = '0;
            S_UPDATE:   cmd.update     = 1'b1;
            S_DONE:     cmd.done       = sts.out_free;
            default:    cmd            = '0;
        endcase
    end
endmodule
`default_nettype wire

### hdl/lmf_dp.sv
// Datapath of the list mode finder: value store, counting scan, best tracker, result register.
// Depends on lmf_pkg and list_mode_finder_assert.svh; commanded by lmf_ctrl.
`default_nettype none
`include "list_mode_finder_assert.svh"
module lmf_dp
    import lmf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [VALUE_BITS-1:0] item_value,
    input  wire lmf_cmd_t              cmd,
    output lmf_sts_t                   sts,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [VALUE_BITS-1:0]      mode_value,
    output logic [COUNT_W-1:0]         mode_count,
    output logic                       overflowed
);
    logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;

    logic [NUM_W-1:0]      num_reg;
    logic                  ovf_reg;
    logic [NUM_W-1:0]      i_reg;
    logic [NUM_W-1:0]      k_reg;
    logic                  cmp_vld_reg;
    logic [NUM_W-1:0]      cnt_reg;
    logic [VALUE_BITS-1:0] cand_reg;
    logic [NUM_W-1:0]      best_cnt_reg;
    logic [VALUE_BITS-1:0] best_val_reg;
    logic                  out_vld_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic [COUNT_W-1:0]    out_cnt_reg;
    logic                  out_ovf_reg;
    logic                  full;

    assign full    = (num_reg == NUM_W'(MAX_ITEMS));
    assign rd_addr = cmd.cand_rd ? i_reg[IDX_W-1:0] : k_reg[IDX_W-1:0];

    assign sts.k_last   = (k_reg == num_reg - NUM_W'(1));
    assign sts.i_last   = (i_reg == num_reg - NUM_W'(1));
    assign sts.out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            mem[num_reg[IDX_W-1:0]] <= item_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg      <= '0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            k_reg        <= '0;
            cmp_vld_reg  <= 1'b0;
            cnt_reg      <= '0;
            best_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan_issue;
            if (cmd.load)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    num_reg <= num_reg + NUM_W'(1);
                end
            end
            if (cmd.cand_lat)
            begin
                k_reg   <= '0;
                cnt_reg <= '0;
            end
            if (cmd.scan_issue)
            begin
                k_reg <= k_reg + NUM_W'(1);
            end
            if (cmp_vld_reg && (rd_data_reg == cand_reg))
            begin
                cnt_reg <= cnt_reg + NUM_W'(1);
            end
            if (cmd.update)
            begin
                i_reg <= i_reg + NUM_W'(1);
                if (cnt_reg > best_cnt_reg)
                begin
                    best_cnt_reg <= cnt_reg;
                end
            end
            if (out_vld_reg && !out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cmd.done)
            begin
                out_vld_reg  <= 1'b1;
                num_reg      <= '0;
                ovf_reg      <= 1'b0;
                i_reg        <= '0;
                best_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cand_lat)
        begin
            cand_reg <= rd_data_reg;
        end
        if (cmd.update && (cnt_reg > best_cnt_reg))
        begin
            best_val_reg <= cand_reg;
        end
        if (cmd.done)
        begin
            out_val_reg <= best_val_reg;
            out_cnt_reg <= COUNT_W'(best_cnt_reg);
            out_ovf_reg <= ovf_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign mode_value = out_val_reg;
    assign mode_count = out_cnt_reg;
    assign overflowed = out_ovf_reg;

    `LMF_ASSERT_NOW(a_num_bound, clk, rst_n, 1'b1, num_reg <= NUM_W'(MAX_ITEMS))
    `LMF_ASSERT_NOW(a_scan_in_range, clk, rst_n, cmd.scan_issue, k_reg < num_reg)
    `LMF_ASSERT_NOW(a_cand_self_match, clk, rst_n, cmd.update, cnt_reg != '0)
    `LMF_ASSERT_NEXT(a_result_nonzero, clk, rst_n, cmd.done, out_vld_reg && out_cnt_reg != '0)
endmodule
`default_nettype wire

### verif/lmf_mode_checker.sv
// Checker for the list mode finder: watches both channels, predicts each result beat
// and compares it field by field. Depends on lmf_pkg; instantiated by testbench.
module lmf_mode_checker
    import lmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [VALUE_BITS-1:0] item_value,
    input  logic                  last_item,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [VALUE_BITS-1:0] mode_value,
    input  logic [COUNT_W-1:0]    mode_count,
    input  logic                  overflowed,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_MAX = (1 << COUNT_W) - 1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_W-1:0]    count;
        logic                  over;
    } mode_result_t;

    logic [VALUE_BITS-1:0] held_vals[MAX_ITEMS];
    int                    held_len;
    bit                    held_over;
    mode_result_t          mode_expect_q[$];
    mode_result_t          want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic mode_result_t tally_mode(input int n, input bit over);
        mode_result_t res;
        int best;
        int hits;
        best      = 0;
        res.value = '0;
        for (int i = 0; i < n; i++)
        begin
            hits = 0;
            for (int k = 0; k < n; k++)
            begin
                if (held_vals[k] == held_vals[i])
                    hits++;
            end
            if (hits > best)
            begin
                best      = hits;
                res.value = held_vals[i];
            end
        end
        if (best > COUNT_MAX)
            best = COUNT_MAX;
        res.count = best[COUNT_W-1:0];
        res.over  = over;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_len  = 0;
            held_over = 1'b0;
            mode_expect_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (mode_expect_q.size() == 0)
                begin
                    $error("result beat with no list closed: mode_value %0h, mode_count %0d",
                           mode_value, mode_count);
                    fail_count++;
                end
                else
                begin
                    want = mode_expect_q.pop_front();
                    if (mode_value !== want.value)
                    begin
                        $error("mode_value: expected %0h, got %0h", want.value, mode_value);
                        fail_count++;
                    end
                    if (mode_count !== want.count)
                    begin
                        $error("mode_count: expected %0d, got %0d", want.count, mode_count);
                        fail_count++;
                    end
                    if (overflowed !== want.over)
                    begin
                        $error("overflowed: expected %0b, got %0b", want.over, overflowed);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (held_len < MAX_ITEMS)
                begin
                    held_vals[held_len] = item_value;
                    held_len++;
                end
                else
                    held_over = 1'b1;
                if (last_item)
                begin
                    mode_expect_q.push_back(tally_mode(held_len, held_over));
                    held_len  = 0;
                    held_over = 1'b0;
                end
            end
        end
        pending = mode_expect_q.size();
    end
endmodule

### verif/testbench.sv
// Top of the list mode finder testbench: clock, reset, list stimulus and verdict.
// Depends on lmf_pkg, list_mode_finder and lmf_mode_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lmf_pkg::*;

    localparam int RANDOM_BEATS = 650;
    localparam int IDLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES = 200;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [VALUE_BITS-1:0] item_value = '0;
    logic                  last_item  = 1'b0;
    logic                  out_stall  = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [VALUE_BITS-1:0] mode_value;
    logic [COUNT_W-1:0]    mode_count;
    logic                  overflowed;

    int fail_count;
    int pending;
    int tx_idle_pct = 25;
    int rx_idle_pct = 86;
    int beats_sent  = 0;
    int lists_sent  = 0;
    int long_lists  = 0;
    int idle_cycles = 0;

    list_mode_finder i_dut (.*);

    lmf_mode_checker u_mode_checker (.*);

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("list_mode_finder regression: fail");
            $finish;
        end
    end

    task automatic send_beat(input logic [VALUE_BITS-1:0] value, input logic closes);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        item_value <= value;
        last_item  <= closes;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_list(input int len, input int kinds);
        logic [VALUE_BITS-1:0] pool[4];
        logic [VALUE_BITS-1:0] value;
        for (int p = 0; p < 4; p++)
        begin
            case ($urandom_range(7))
                0: pool[p] = '0;
                1: pool[p] = '1;
                default: pool[p] = VALUE_BITS'($urandom);
            endcase
        end
        for (int n = 1; n <= len; n++)
        begin
            if (kinds == 0)
                value = VALUE_BITS'($urandom);
            else
                value = pool[$urandom_range(kinds - 1)];
            send_beat(value, n == len);
        end
        lists_sent++;
        if (len > MAX_ITEMS)
            long_lists++;
    endtask

    // hold valid low until every result is out, then switch idling mix
    task automatic hold_until_drained(input int tx_pct, input int rx_pct);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(posedge clk);
    endtask

    initial
    begin
        int base_beats;
        int rand_lists;
        int phase;
        int stage;
        int pick;
        int len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(16'hFFFF, 1'b1);

        send_beat(16'h0000, 1'b0);
        send_beat(16'h0000, 1'b1);

        send_beat(16'h0005, 1'b0);
        send_beat(16'h0007, 1'b0);
        send_beat(16'h0007, 1'b0);
        send_beat(16'h0005, 1'b1);

        send_beat(16'h8000, 1'b0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'h0002, 1'b0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'h0002, 1'b1);

        send_beat(16'hAAAA, 1'b0);
        send_beat(16'h5555, 1'b0);
        send_beat(16'h5555, 1'b1);
        lists_sent += 5;

        hold_until_drained(25, 86);

        base_beats = beats_sent;
        rand_lists = 0;
        phase      = 0;
        while (beats_sent - base_beats < RANDOM_BEATS)
        begin
            stage = (beats_sent - base_beats) * 3 / RANDOM_BEATS;
            if (stage != phase)
            begin
                phase = stage;
                if (phase == 1)
                    hold_until_drained(86, 25);
                else
                    hold_until_drained(0, 0);
            end
            case (rand_lists)
                0: send_list(MAX_ITEMS + 1, 2);
                1: send_list(MAX_ITEMS, 1);
                2: send_list(MAX_ITEMS + 8, 3);
                default:
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        len = $urandom_range(MAX_ITEMS + 8, MAX_ITEMS + 1);
                    else if (pick < 10)
                        len = MAX_ITEMS;
                    else if (pick < 20)
                        len = $urandom_range(MAX_ITEMS - 1, 13);
                    else
                        len = $urandom_range(12, 1);
                    send_list(len, $urandom_range(4));
                end
            endcase
            rand_lists++;
        end

        hold_until_drained(0, 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d lists in %0d beats, %0d longer than the store,",
                 lists_sent, beats_sent, long_lists);
        $display("with ties, full stores, dropped closing beats and three idling mixes");
        if (fail_count == 0)
            $display("list_mode_finder regression: pass");
        else
            $display("list_mode_finder regression: fail");
        $finish;
    end
endmodule
